[design/upd_pkg.sv]
// shared types, constants and hex digit decode for the uri percent decoder
package upd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_HI   = 2'd1,
    PH_LO   = 2'd2
  } phase_t;

  localparam logic [7:0] CHAR_PLUS    = 8'h2b;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_0       = 8'h30;
  localparam logic [7:0] CHAR_9       = 8'h39;
  localparam logic [7:0] CHAR_LA      = 8'h61;
  localparam logic [7:0] CHAR_LF      = 8'h66;
  localparam logic [7:0] CHAR_UA      = 8'h41;
  localparam logic [7:0] CHAR_UF      = 8'h46;
  localparam logic [7:0] HEX_TEN      = 8'd10;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] t;
    d = '0;
    t = '0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      t = c - CHAR_0;
      d.ok = 1'b1;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      t = c - CHAR_LA + HEX_TEN;
      d.ok = 1'b1;
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      t = c - CHAR_UA + HEX_TEN;
      d.ok = 1'b1;
    end
    d.val = t[3:0];
    return d;
  endfunction

endpackage

[design/uri_percent_decoder_core.sv]
// uri percent decoder: one byte in, one result out, with output skid buffer
//
// input channel: in_valid / in_stall carry in_data (byte and end-of-string flag).
// result channel: out_valid / out_stall carry out_data; every accepted item yields
// exactly one result item, whose out_valid field says whether it holds a byte.
// config: cfg_we writes cfg_wdata into the keep-zero-bytes register; write it
// only while no item is in flight.
// path: each accepted item's result is registered, via the skid register if held.
// throughput: one item per cycle while in_stall is low, set by the single decode
// stage feeding the result register.
// stall: when out_stall holds a result, one more item is taken into a skid
// register; in_stall then rises until the result register drains.
// reset: rst_n low clears both buffers, the escape phase, the first digit and
// the keep-zero-bytes register.
module uri_percent_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  upd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output upd_pkg::out_item_t out_data
);

  logic               keep_zero_r;
  upd_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         first_digit_r, first_digit_nxt;
  logic               out_valid_r, out_valid_nxt;
  upd_pkg::out_item_t out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  upd_pkg::out_item_t skid_data_r, skid_data_nxt;
  upd_pkg::out_item_t result;
  upd_pkg::hex_digit_t hi_d, lo_d;
  logic [7:0]         esc_val;
  logic               in_acc, out_acc;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_acc   = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign hi_d    = upd_pkg::hex_decode(first_digit_r);
  assign lo_d    = upd_pkg::hex_decode(in_data.in_byte);
  assign esc_val = (hi_d.ok && lo_d.ok) ? {hi_d.val, lo_d.val} : 8'd0;

  // next escape phase
  always_comb begin
    phase_nxt       = phase_r;
    first_digit_nxt = first_digit_r;
    if (in_acc) begin
      case (phase_r)
        upd_pkg::PH_HI: begin
          first_digit_nxt = in_data.in_byte;
          phase_nxt       = upd_pkg::PH_LO;
        end
        upd_pkg::PH_LO: begin
          phase_nxt = upd_pkg::PH_TEXT;
        end
        default: begin
          phase_nxt = (in_data.in_byte == upd_pkg::CHAR_PERCENT) ?
                      upd_pkg::PH_HI : upd_pkg::PH_TEXT;
        end
      endcase
      if (in_data.in_last) begin
        phase_nxt = upd_pkg::PH_TEXT;
      end
    end
  end

  // result for the current item
  always_comb begin
    result          = '0;
    result.out_last = in_data.in_last;
    case (phase_r)
      upd_pkg::PH_HI: begin
        result.out_valid = 1'b0;
      end
      upd_pkg::PH_LO: begin
        if (esc_val != 8'd0 || keep_zero_r) begin
          result.out_valid = 1'b1;
          result.out_byte  = esc_val;
        end
      end
      default: begin
        if (in_data.in_byte == upd_pkg::CHAR_PLUS) begin
          result.out_valid = 1'b1;
          result.out_byte  = upd_pkg::CHAR_SPACE;
        end else if (in_data.in_byte != upd_pkg::CHAR_PERCENT) begin
          result.out_valid = 1'b1;
          result.out_byte  = in_data.in_byte;
        end
      end
    endcase
  end

  // output register and skid buffer
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_acc) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (in_acc) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_zero_r   <= 1'b0;
      phase_r       <= upd_pkg::PH_TEXT;
      first_digit_r <= 8'd0;
      out_valid_r   <= 1'b0;
      skid_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        keep_zero_r <= cfg_wdata;
      end
      phase_r       <= phase_nxt;
      first_digit_r <= first_digit_nxt;
      out_valid_r   <= out_valid_nxt;
      skid_valid_r  <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for uri_percent_decoder_core: random and directed byte streams
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 370;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_wdata = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  upd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  upd_pkg::out_item_t out_data;

  upd_pkg::in_item_t  encoded_q[$];
  upd_pkg::out_item_t decoded_q[$];
  int        bytes_queued = 0;
  int        bytes_taken = 0;
  int        mismatches = 0;
  logic      in_taken = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_go = 1'b0;
  int        hold_cycles = 0;

  // decoder state mirror
  upd_pkg::phase_t esc_phase = upd_pkg::PH_TEXT;
  logic [7:0]      first_char = 8'h00;
  logic            keep_zero = 1'b0;

  uri_percent_decoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] v);
    logic [7:0] d;
    d = 8'h00;
    hex_nibble = 1'b1;
    if (c >= "0" && c <= "9") begin
      d = c - 8'h30;
    end else if (c >= "a" && c <= "f") begin
      d = c - 8'h61 + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - 8'h41 + 8'd10;
    end else begin
      hex_nibble = 1'b0;
    end
    v = d[3:0];
  endfunction

  function automatic upd_pkg::out_item_t decode_byte(input upd_pkg::in_item_t it);
    upd_pkg::out_item_t r;
    logic [3:0]         hi, lo;
    logic               ok_hi, ok_lo;
    logic [7:0]         v;
    r = '0;
    r.out_last = it.in_last;
    case (esc_phase)
      upd_pkg::PH_HI: begin
        first_char = it.in_byte;
        esc_phase = upd_pkg::PH_LO;
      end
      upd_pkg::PH_LO: begin
        ok_hi = hex_nibble(first_char, hi);
        ok_lo = hex_nibble(it.in_byte, lo);
        v = (ok_hi && ok_lo) ? {hi, lo} : 8'h00;
        if (v != 8'h00 || keep_zero) begin
          r.out_valid = 1'b1;
          r.out_byte = v;
        end
        esc_phase = upd_pkg::PH_TEXT;
      end
      default: begin
        esc_phase = upd_pkg::PH_TEXT;
        if (it.in_byte == upd_pkg::CHAR_PLUS) begin
          r.out_valid = 1'b1;
          r.out_byte = upd_pkg::CHAR_SPACE;
        end else if (it.in_byte == upd_pkg::CHAR_PERCENT) begin
          esc_phase = upd_pkg::PH_HI;
        end else begin
          r.out_valid = 1'b1;
          r.out_byte = it.in_byte;
        end
      end
    endcase
    if (it.in_last) esc_phase = upd_pkg::PH_TEXT;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (encoded_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= encoded_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold
  always @(negedge clk) begin
    if (hold_go && hold_cycles < HOLD_LEN) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: results checked first, then accepted items predicted
  always @(posedge clk) begin
    upd_pkg::out_item_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          $error("result item with none expected: %0h", out_data);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_valid !== want.out_valid) begin
            $error("out_valid expected %0h got %0h", want.out_valid, out_data.out_valid);
            mismatches++;
          end
          if (out_data.out_byte !== want.out_byte) begin
            $error("out_byte expected %0h got %0h", want.out_byte, out_data.out_byte);
            mismatches++;
          end
          if (out_data.out_last !== want.out_last) begin
            $error("out_last expected %0h got %0h", want.out_last, out_data.out_last);
            mismatches++;
          end
        end
      end
      if (cfg_we) keep_zero = cfg_wdata;
      if (in_valid && !in_stall) begin
        decoded_q.push_back(decode_byte(in_data));
        bytes_taken++;
      end
    end
  end

  task automatic push_item(input logic [7:0] c, input logic l);
    upd_pkg::in_item_t it;
    it.in_byte = c;
    it.in_last = l;
    encoded_q.push_back(it);
    bytes_queued++;
  endtask

  task automatic push_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) begin
      push_item(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] rand_hex_char();
    int idx;
    idx = $urandom_range(21);
    if (idx < 10) return upd_pkg::CHAR_0 + 8'(idx);
    if (idx < 16) return upd_pkg::CHAR_LA + 8'(idx - 10);
    return upd_pkg::CHAR_UA + 8'(idx - 16);
  endfunction

  function automatic logic [7:0] escape_digit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return rand_hex_char();
    if (sel < 84) return upd_pkg::CHAR_PLUS;
    if (sel < 88) return upd_pkg::CHAR_PERCENT;
    return 8'($urandom_range(255));
  endfunction

  task automatic gen_string();
    logic [7:0] str_q[$];
    int         tokens;
    int         sel;
    tokens = $urandom_range(10, 1);
    for (int t = 0; t < tokens; t++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        str_q.push_back(upd_pkg::CHAR_PERCENT);
        if ($urandom_range(19) == 0) begin
          str_q.push_back(upd_pkg::CHAR_0);
          str_q.push_back(upd_pkg::CHAR_0);
        end else begin
          str_q.push_back(escape_digit());
          str_q.push_back(escape_digit());
        end
      end else if (sel < 55) begin
        str_q.push_back(upd_pkg::CHAR_PLUS);
      end else begin
        str_q.push_back(8'($urandom_range(255)));
      end
    end
    // escape cut short by end of string
    sel = $urandom_range(9);
    if (sel == 0) begin
      str_q.push_back(upd_pkg::CHAR_PERCENT);
    end else if (sel == 1) begin
      str_q.push_back(upd_pkg::CHAR_PERCENT);
      str_q.push_back(rand_hex_char());
    end
    foreach (str_q[i]) push_item(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (bytes_taken != bytes_queued || decoded_q.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input logic keep, input int send_pct, input int recv_pct,
                           input logic with_hold);
    int start;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= keep;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (with_hold) hold_go = 1'b1;
    start = bytes_queued;
    while (bytes_queued - start < PHASE_LEN) gen_string();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: digit cases, zero and invalid escapes, specials inside an escape
    push_text("%41%6a%Ff%00%zG%+%+a", 1'b0);
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b1);
    push_text("%", 1'b1);
    push_text("%4", 1'b1);
    run_phase(1'b1, 0, 0, 1'b1);
    run_phase(1'b0, 79, 0, 1'b0);
    run_phase(1'b1, 0, 79, 1'b0);
    run_phase(1'b0, 22, 22, 1'b0);
    wait_idle();
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

[sim.f]
design/upd_pkg.sv
design/uri_percent_decoder_core.sv
tb/sv/tb_top.sv
